FILE: rtl/tgrdm_pkg.sv
// Shared types and constants for the tile red-dominance mask block.
`default_nettype none
package tgrdm_pkg;
	localparam int PIX_W      = 8;
	localparam int MARGIN_W   = 10;
	localparam int FLOOR_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	// index of the last pixel of a tile, wide enough for tiles of up to 64 pixels
	localparam int PIX_IDX_W  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_RED_MARGIN     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RED_MEAN_FLOOR = 1'b1;

	localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd25;
	localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 8'd45;

	typedef struct packed {
		logic                 bank;
		logic                 bright;
		logic [PIX_IDX_W-1:0] last_idx;
	} tile_desc_t;
endpackage
`default_nettype wire

FILE: rtl/tgrdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tgrdm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tgrdm_front.sv
// Front end: per-pixel dominance flag, red sum and tile-end mean test.
`default_nettype none
module tgrdm_front #(
	parameter int TILE_PIXELS_MAX = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_fire,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]         blue,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]         green,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]         red,
	input  wire logic                                tile_end,
	input  wire logic [tgrdm_pkg::MARGIN_W-1:0]      red_margin,
	input  wire logic [tgrdm_pkg::FLOOR_W-1:0]       red_mean_floor,
	output      logic                                ram_we,
	output      logic [((TILE_PIXELS_MAX > 1) ? $clog2(TILE_PIXELS_MAX) : 1):0] ram_waddr,
	output      logic                                ram_wdata,
	output      logic                                desc_push,
	output      tgrdm_pkg::tile_desc_t               desc
);
	import tgrdm_pkg::*;

	localparam int IDX_W = (TILE_PIXELS_MAX > 1) ? $clog2(TILE_PIXELS_MAX) : 1;
	localparam int CNT_W = $clog2(TILE_PIXELS_MAX + 1);
	localparam int SUM_W = $clog2(TILE_PIXELS_MAX * 255 + 1);
	localparam int CMP_W = MARGIN_W + 1;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] facc_q;   // floor times pixel count, built by addition
	logic             bank_q;

	logic [CNT_W-1:0] cnt_n;
	logic [SUM_W-1:0] sum_n;
	logic [SUM_W-1:0] facc_n;
	logic             tile_done;
	logic [CMP_W-1:0] twice_red;
	logic [CMP_W-1:0] gb_margin;

	always_comb begin
		twice_red = CMP_W'({red, 1'b0});
		gb_margin = CMP_W'(green) + CMP_W'(blue) + CMP_W'(red_margin);
		cnt_n     = cnt_q + CNT_W'(1);
		sum_n     = sum_q + SUM_W'(red);
		facc_n    = facc_q + SUM_W'(red_mean_floor);
		tile_done = tile_end | (cnt_n == CNT_W'(TILE_PIXELS_MAX));
	end

	assign ram_we        = in_fire;
	assign ram_waddr     = {bank_q, cnt_q[IDX_W-1:0]};
	assign ram_wdata     = (twice_red >= gb_margin);
	assign desc_push     = in_fire & tile_done;
	assign desc.bank     = bank_q;
	assign desc.bright   = (sum_n >= facc_n);
	assign desc.last_idx = PIX_IDX_W'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			facc_q <= '0;
			bank_q <= 1'b0;
		end else if (in_fire) begin
			if (tile_done) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				facc_q <= '0;
				bank_q <= ~bank_q;
			end else begin
				cnt_q  <= cnt_n;
				sum_q  <= sum_n;
				facc_q <= facc_n;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tgrdm_desc_q.sv
// Two-entry queue of finished tile descriptors between front and back.
`default_nettype none
module tgrdm_desc_q (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire tgrdm_pkg::tile_desc_t push_desc,
	input  wire logic                  pop,
	output      logic                  full,
	output      logic                  valid,
	output      tgrdm_pkg::tile_desc_t head
);
	import tgrdm_pkg::*;

	localparam int DEPTH = 2;

	tile_desc_t  ent_q [DEPTH];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;

	assign full  = (cnt_q == 2'(DEPTH));
	assign valid = (cnt_q != 2'd0);
	assign head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tgrdm_back.sv
// Back end: reads a tile's flags in order and queues the mask beats.
`default_nettype none
module tgrdm_back #(
	parameter int TILE_PIXELS_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  desc_valid,
	input  wire tgrdm_pkg::tile_desc_t desc,
	output      logic                  desc_pop,
	output      logic                  ram_re,
	output      logic [((TILE_PIXELS_MAX > 1) ? $clog2(TILE_PIXELS_MAX) : 1):0] ram_raddr,
	input  wire logic                  ram_rdata,
	input  wire logic                  pop,
	output      logic                  empty,
	output      logic                  mask_bit,
	output      logic                  run_last
);
	import tgrdm_pkg::*;

	localparam int IDX_W   = (TILE_PIXELS_MAX > 1) ? $clog2(TILE_PIXELS_MAX) : 1;
	localparam int ODEPTH  = 2;

	logic [IDX_W-1:0] rd_idx_q;
	logic             v_s1;
	logic             last_s1;
	logic             bright_s1;

	logic [1:0]       ofifo_q [ODEPTH];   // {mask, last}
	logic             owptr_q;
	logic             orptr_q;
	logic [1:0]       ocnt_q;

	logic [1:0]       used;
	logic             pop_fire;
	logic             issue;
	logic             at_last;

	always_comb begin
		used     = ocnt_q + 2'(v_s1);
		pop_fire = pop & (ocnt_q != 2'd0);
		// count the beat in flight in the RAM read against the output room
		issue    = desc_valid & ((used < 2'(ODEPTH)) | ((used == 2'(ODEPTH)) & pop_fire));
		at_last  = (rd_idx_q == IDX_W'(desc.last_idx));
	end

	assign desc_pop  = issue & at_last;
	assign ram_re    = issue;
	assign ram_raddr = {desc.bank, rd_idx_q};
	assign empty     = (ocnt_q == 2'd0);
	assign mask_bit  = ofifo_q[orptr_q][1];
	assign run_last  = ofifo_q[orptr_q][0];

	always_ff @(posedge clk) begin
		last_s1   <= at_last;
		bright_s1 <= desc.bright;
		if (v_s1) begin
			ofifo_q[owptr_q] <= {bright_s1 & ram_rdata, last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			owptr_q  <= 1'b0;
			orptr_q  <= 1'b0;
			ocnt_q   <= 2'd0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				rd_idx_q <= at_last ? '0 : rd_idx_q + IDX_W'(1);
			end
			if (v_s1) begin
				owptr_q <= ~owptr_q;
			end
			if (pop_fire) begin
				orptr_q <= ~orptr_q;
			end
			ocnt_q <= ocnt_q + 2'(v_s1) - 2'(pop_fire);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tile_gated_red_dominance_mask_top.sv
// Top level: config registers, front end, tile queue, flag RAM and back end.
// Input: one pixel per cycle; push is held off (full) only while both flag banks
// hold tiles whose flags are not all read out by the back end.
// Output: after a tile's last pixel beat, its flags are read from the flag RAM and pass
// through the output queue; then one mask beat per cycle while pop is held.
// Reset: config registers return to their defaults, counters and queues clear;
// the flag RAM is not cleared.
`default_nettype none
module tile_gated_red_dominance_mask_top #(
	parameter int TILE_PIXELS_MAX = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output      logic                              full,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]       blue,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]       green,
	input  wire logic [tgrdm_pkg::PIX_W-1:0]       red,
	input  wire logic                              tile_end,
	output      logic                              empty,
	input  wire logic                              pop,
	output      logic                              mask_bit,
	output      logic                              run_last,
	input  wire logic                              cfg_we,
	input  wire logic [tgrdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tgrdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import tgrdm_pkg::*;

	localparam int IDX_W  = (TILE_PIXELS_MAX > 1) ? $clog2(TILE_PIXELS_MAX) : 1;
	localparam int RAM_D  = 2 * (2 ** IDX_W);

	logic [MARGIN_W-1:0] margin_q;
	logic [FLOOR_W-1:0]  floor_q;

	logic             in_fire;
	logic             ram_we;
	logic [IDX_W:0]   ram_waddr;
	logic             ram_wdata;
	logic             ram_re;
	logic [IDX_W:0]   ram_raddr;
	logic             ram_rdata;
	logic             desc_push;
	tile_desc_t       push_desc;
	logic             desc_pop;
	logic             desc_valid;
	tile_desc_t       head_desc;

	assign in_fire = push & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RST;
			floor_q  <= FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_MARGIN:     margin_q <= cfg_wdata[MARGIN_W-1:0];
				REG_RED_MEAN_FLOOR: floor_q  <= cfg_wdata[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	tgrdm_front #(
		.TILE_PIXELS_MAX(TILE_PIXELS_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.tile_end      (tile_end),
		.red_margin    (margin_q),
		.red_mean_floor(floor_q),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.desc_push     (desc_push),
		.desc          (push_desc)
	);

	tgrdm_desc_q u_desc_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (desc_push),
		.push_desc(push_desc),
		.pop      (desc_pop),
		.full     (full),
		.valid    (desc_valid),
		.head     (head_desc)
	);

	tgrdm_ram #(
		.WIDTH(1),
		.DEPTH(RAM_D)
	) u_flag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tgrdm_back #(
		.TILE_PIXELS_MAX(TILE_PIXELS_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid),
		.desc      (head_desc),
		.desc_pop  (desc_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.pop       (pop),
		.empty     (empty),
		.mask_bit  (mask_bit),
		.run_last  (run_last)
	);

	// pixel writes never land in the bank that is being emitted
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && desc_valid) |-> (ram_waddr[IDX_W] != head_desc.bank))
		else $error("flag write into the bank being emitted");

	// both banks fill up only through a pixel beat
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a pixel beat");

	// a tile leaves the queue only if one is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |-> desc_valid)
		else $error("tile descriptor popped from empty queue");
endmodule
`default_nettype wire
